@@ design/rsip_pkg.sv @@
package rsip_pkg;

  localparam int unsigned POS_W = 13;
  localparam int unsigned MAG_W = 34;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned VALUE_W = 32;

  localparam logic [POS_W-1:0] MAX_LENGTH = 13'd4096;
  localparam logic [MAG_W-1:0] MAG_CAP = 34'h2_0000_0000;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

  localparam logic [VALUE_W-1:0] INT_MAX_VAL = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] INT_MIN_VAL = 32'h8000_0000;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_UX = 8'h58;

  typedef enum logic [2:0] {
    PH_BLANK,
    PH_AFTER_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_RANGE
  } status_t;

  typedef struct packed {
    phase_t           phase;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             dnz;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] stop;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_BLANK, neg: 1'b0, mag: '0, dnz: 1'b0, pos: '0, stop: '0
  };

  typedef struct packed {
    logic [POS_W-1:0]   end_offset;
    status_t            status;
    logic [VALUE_W-1:0] value;
  } result_t;

endpackage

@@ design/rsip_step.sv @@
module rsip_step (
  input  rsip_pkg::parse_state_t             st,
  input  logic [7:0]                         char_code,
  input  logic                               last_char,
  input  logic [rsip_pkg::RADIX_W-1:0]       radix,
  output rsip_pkg::parse_state_t             st_nxt,
  output rsip_pkg::result_t                  res
);
  import rsip_pkg::*;

  // digit value of a character; valid flag low for non-digits
  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        t = c - 8'h30;
        return {1'b1, t[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        t = c - 8'h61 + 8'd10;
        return {1'b1, t[5:0]};
      end else if (c >= 8'h41 && c <= 8'h5A) begin
        t = c - 8'h41 + 8'd10;
        return {1'b1, t[5:0]};
      end
      return 7'd0;
    end
  endfunction

  logic [6:0]         dig;
  logic               dig_ok;
  logic [39:0]        prod;
  logic [MAG_W-1:0]   mag_sat;
  logic               is_blank;
  logic               is_sign;
  logic               is_x;
  logic               start_zero;
  logic               invalid;
  logic [POS_W-1:0]   pos_p1;
  parse_state_t       upd;

  assign dig        = digit_of(char_code);
  assign dig_ok     = dig[6] && (dig[5:0] < radix);
  assign prod       = 40'(st.mag) * 40'(radix) + 40'(dig[5:0]);
  assign mag_sat    = (prod > 40'(MAG_CAP)) ? MAG_CAP : prod[MAG_W-1:0];
  assign is_blank   = (char_code == CH_SPACE) || (char_code == CH_TAB);
  assign is_sign    = (char_code == CH_PLUS) || (char_code == CH_MINUS);
  assign is_x       = (char_code == CH_LX) || (char_code == CH_UX);
  assign start_zero = (radix == RADIX_HEX) && (char_code == CH_ZERO) && !last_char;
  assign pos_p1     = st.pos + 13'd1;

  always_comb begin
    upd     = st;
    invalid = 1'b0;
    unique case (st.phase)
      PH_BLANK, PH_AFTER_SIGN, PH_ZERO, PH_DIGITS: begin
        if (st.phase == PH_BLANK && is_blank) begin
          invalid = last_char;
        end else if (st.phase == PH_BLANK && is_sign) begin
          upd.neg   = (char_code == CH_MINUS);
          upd.phase = PH_AFTER_SIGN;
          invalid   = last_char;
        end else if ((st.phase == PH_BLANK || st.phase == PH_AFTER_SIGN) && start_zero) begin
          upd.mag   = '0;
          upd.dnz   = 1'b1;
          upd.phase = PH_ZERO;
        end else if (st.phase == PH_ZERO && is_x) begin
          upd.dnz   = 1'b0;
          upd.phase = PH_DIGITS;
        end else if (dig_ok) begin
          upd.mag   = mag_sat;
          upd.dnz   = 1'b1;
          upd.phase = PH_DIGITS;
        end else begin
          upd.stop  = st.dnz ? st.pos : '0;
          upd.phase = PH_STOPPED;
        end
      end
      default: begin
      end
    endcase
    if (st.pos < MAX_LENGTH) begin
      upd.pos = pos_p1;
    end

    res.value      = '0;
    res.status     = ST_OK;
    res.end_offset = '0;
    if (invalid) begin
      res.status = ST_INVALID;
    end else begin
      if (upd.phase == PH_STOPPED) begin
        res.end_offset = upd.stop;
      end else if (upd.dnz) begin
        res.end_offset = (pos_p1 > MAX_LENGTH) ? MAX_LENGTH : pos_p1;
      end
      if (upd.neg) begin
        if (upd.mag > 34'h0_8000_0000) begin
          res.value  = INT_MIN_VAL;
          res.status = ST_RANGE;
        end else begin
          res.value = 32'd0 - upd.mag[VALUE_W-1:0];
        end
      end else begin
        if (upd.mag > 34'h0_7FFF_FFFF) begin
          res.value  = INT_MAX_VAL;
          res.status = ST_RANGE;
        end else begin
          res.value = upd.mag[VALUE_W-1:0];
        end
      end
    end

    st_nxt = last_char ? STATE_CLEAR : upd;
  end

endmodule

@@ design/radix_string_to_int_parser_core.sv @@
// Radix string-to-integer parser.
// in_*  : one character word per transfer; in_tdata[7:0] = char_code,
//         in_tlast marks the last character of the substring.
// out_* : one result word per substring, sent for the word carrying in_tlast.
//         out_tdata = {zero pad, end_offset[12:0], status[1:0], value[31:0]}.
// cfg_* : cfg_wr_en writes cfg_wr_data into the radix register (reset 10);
//         write only while no substring is in flight.
// Characters are parsed from the input register; results are registered for out_*.
// Throughput: one character per cycle unless a held result stalls a last character;
// the input register and the result register decouple the channels, each
// character does one 34x6 multiply-add.
// Reset clears the parse state and both registers' valid flags; radix -> 10.
// When out_tready stays low, the held result blocks only the next word that
// carries in_tlast; plain characters keep flowing, then in_tready drops once
// a last character waits in the input register.
module radix_string_to_int_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,    // [7:0] char_code
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [47:0]                    out_tdata,   // value, status, end_offset, pad
  input  logic                           cfg_wr_en,
  input  logic [rsip_pkg::RADIX_W-1:0]   cfg_wr_data
);
  import rsip_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic               s1_valid_r;
  logic [7:0]         s1_char_r;
  logic               s1_last_r;
  logic               out_valid_r;
  result_t            out_res_r;
  parse_state_t       st_r;
  parse_state_t       st_nxt;
  result_t            res;
  logic               out_free;
  logic               advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || advance;

  rsip_step u_step (
    .st        (st_r),
    .char_code (s1_char_r),
    .last_char (s1_last_r),
    .radix     (radix_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_CLEAR;
    end else begin
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (advance && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == ST_INVALID |->
      out_res_r.value == '0 && out_res_r.end_offset == '0)
    else $error("invalid result with nonzero value or offset");

  a_range_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == ST_RANGE |->
      out_res_r.value == INT_MAX_VAL || out_res_r.value == INT_MIN_VAL)
    else $error("range result not saturated");

  a_mag_cap: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mag <= MAG_CAP && st_r.pos <= MAX_LENGTH)
    else $error("accumulator or position beyond cap");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> st_r.phase == PH_BLANK && st_r.pos == '0 && out_valid_r)
    else $error("parse state not cleared after last character");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_res_r))
    else $error("pending result overwritten");
`endif

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import rsip_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;          // [7:0] char_code
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;             // [31:0] value, [33:32] status, [46:34] end_offset, pad
  logic cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0] cfg_wr_data = RADIX_RESET;

  radix_string_to_int_parser_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // parser state as the block should hold it
  logic [RADIX_W-1:0] radix_m = RADIX_RESET;
  phase_t ph_m = PH_BLANK;
  logic neg_m = 1'b0;
  logic [MAG_W-1:0] mag_m = '0;
  logic dnz_m = 1'b0;
  logic [POS_W-1:0] pos_m = '0;
  logic [POS_W-1:0] stop_m = '0;

  result_t parse_results_due[$];
  int errors = 0;
  int chars_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  function automatic void take_digit_m(logic [7:0] c, logic [POS_W-1:0] pos);
    logic [7:0] d;
    logic [63:0] acc;
    d = 8'hFF;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "z") d = c - "a" + 8'd10;
    else if (c >= "A" && c <= "Z") d = c - "A" + 8'd10;
    if (d < {2'b00, radix_m}) begin
      acc = 64'(mag_m) * radix_m + d;
      mag_m = (acc > 64'(MAG_CAP)) ? MAG_CAP : acc[MAG_W-1:0];
      dnz_m = 1'b1;
      ph_m = PH_DIGITS;
    end else begin
      stop_m = dnz_m ? pos : '0;
      ph_m = PH_STOPPED;
    end
  endfunction

  function automatic void start_number_m(logic [7:0] c, logic [POS_W-1:0] pos, logic last);
    // in hex a leading zero may open a 0x prefix, unless it ends the string
    if (radix_m == RADIX_HEX && c == CH_ZERO && !last) begin
      mag_m = '0;
      dnz_m = 1'b1;
      ph_m = PH_ZERO;
    end else begin
      take_digit_m(c, pos);
    end
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input logic last, output result_t r);
    logic [POS_W-1:0] pos;
    bit invalid;
    pos = pos_m;
    invalid = 1'b0;
    r = '0;
    case (ph_m)
      PH_BLANK: begin
        if (c == CH_SPACE || c == CH_TAB) begin
          invalid = last;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg_m = (c == CH_MINUS);
          ph_m = PH_AFTER_SIGN;
          invalid = last;
        end else begin
          start_number_m(c, pos, last);
        end
      end
      PH_AFTER_SIGN: start_number_m(c, pos, last);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          dnz_m = 1'b0;
          ph_m = PH_DIGITS;
        end else begin
          take_digit_m(c, pos);
        end
      end
      PH_DIGITS: take_digit_m(c, pos);
      default: ;
    endcase
    if (pos_m < MAX_LENGTH) pos_m++;
    if (!last) return 1'b0;
    if (invalid) begin
      r.status = ST_INVALID;
    end else begin
      if (ph_m == PH_STOPPED) r.end_offset = stop_m;
      else if (dnz_m) r.end_offset = (pos == MAX_LENGTH) ? MAX_LENGTH : pos + 1'b1;
      if (neg_m) begin
        if (mag_m > 34'h0_8000_0000) begin
          r.value = INT_MIN_VAL;
          r.status = ST_RANGE;
        end else begin
          r.value = ~mag_m[31:0] + 32'd1;
        end
      end else begin
        if (mag_m > 34'h0_7FFF_FFFF) begin
          r.value = INT_MAX_VAL;
          r.status = ST_RANGE;
        end else begin
          r.value = mag_m[31:0];
        end
      end
    end
    ph_m = PH_BLANK;
    neg_m = 1'b0;
    mag_m = '0;
    dnz_m = 1'b0;
    pos_m = '0;
    stop_m = '0;
    return 1'b1;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 200)
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t r;
    result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (parse_char(in_tdata, in_tlast, r)) parse_results_due.push_back(r);
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[46:0]);
        if (parse_results_due.size() == 0) begin
          errors++;
          if (errors <= 200)
            $display("%0t unexpected word: expected none, actual value %0h status %0d offset %0d",
                     $time, got.value, got.status, got.end_offset);
        end else begin
          r = parse_results_due.pop_front();
          check_field("value", r.value, got.value);
          check_field("status", 32'(r.status), 32'(got.status));
          check_field("end_offset", 32'(r.end_offset), 32'(got.end_offset));
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    // let the checker log the word accepted at this edge first
    @(posedge clk);
    while (parse_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radix_m = r;
  endtask

  task automatic send_random_string();
    logic [7:0] s[$];
    int n;
    int lim;
    int d;
    lim = (radix_m > 36) ? 36 : radix_m;
    if ($urandom_range(99) < 15) begin
      // plain noise
      repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 3)) s.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
      case ($urandom_range(3))
        0: s.push_back(CH_MINUS);
        1: s.push_back(CH_PLUS);
        default: ;
      endcase
      if ((radix_m == RADIX_HEX && $urandom_range(1)) || $urandom_range(15) == 0) begin
        s.push_back(CH_ZERO);
        s.push_back($urandom_range(1) ? CH_LX : CH_UX);
      end
      n = ($urandom_range(4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (n) begin
        d = (lim == 0) ? 0 : $urandom_range(lim - 1);
        if (d < 10) s.push_back(8'("0" + d));
        else s.push_back(8'(($urandom_range(1) ? "a" : "A") + d - 10));
      end
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 4)) s.push_back(8'($urandom_range(255)));
    end
    if (s.size() == 0) s.push_back(8'($urandom_range(255)));
    foreach (s[i]) send_word(s[i], i == s.size() - 1);
  endtask

  task automatic test_decimal_edges();
    // radix still at its reset value here
    send_text(" \t+42");
    send_text("-2147483648");
    send_text("2147483647");
    send_text("2147483648");
    send_text("-2147483649");
    send_text("99999999999999999999");
    send_text(" \t ");
    send_text("-");
    send_text("\t+");
    send_text("abc");
    send_text("12a34");
    send_text("+ 5");
    send_text("007");
    send_word(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_hex_prefix();
    write_radix(RADIX_HEX);
    send_text("0x");
    send_text("0X1fF");
    send_text("0");
    send_text("-0xZ");
    send_text("0g");
    send_text("7fffffff");
    send_text("-80000000");
    send_text("0x100000000");
    send_text(" -ABCdef");
    drain();
  endtask

  task automatic test_radix_extremes();
    write_radix(6'd2);
    send_text("1012");
    send_text("-1111111111111111111111111111111111");
    write_radix(6'd36);
    send_text("zZ");
    send_text("-Zz9!");
    write_radix(6'd0);
    send_text("5");
    send_text("+0");
    write_radix(6'd1);
    send_text("001");
    write_radix(6'd37);
    send_text("a0");
    write_radix(6'd63);
    send_text("zz");
    send_text("!zz");
    drain();
  endtask

  task automatic test_long_substrings();
    // long blank run, then a digit run that drives the accumulator to its cap
    write_radix(RADIX_RESET);
    for (int i = 0; i < 200; i++) send_word(CH_SPACE, 1'b0);
    send_word("5", 1'b1);
    for (int i = 0; i < 60; i++) send_word("1", 1'b0);
    send_word("g", 1'b0);
    send_word(CH_SPACE, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left <= 300;
    repeat (25) send_random_string();
    drain();
  endtask

  task automatic test_random(input int idle_pct, input int stall, input int n_chars);
    int target;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      if ($urandom_range(11) == 0) begin
        case ($urandom_range(7))
          0: write_radix(6'd2);
          1: write_radix(6'd8);
          2: write_radix(6'd10);
          3, 4: write_radix(RADIX_HEX);
          5: write_radix(6'd36);
          default: write_radix(6'($urandom_range(63)));
        endcase
      end
      send_random_string();
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_decimal_edges();
    test_hex_prefix();
    test_radix_extremes();
    test_long_substrings();
    test_backpressure();
    test_random(0, 0, 260);
    test_random(46, 0, 260);
    test_random(0, 46, 260);
    test_random(33, 33, 260);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && parse_results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/rsip_pkg.sv
design/rsip_step.sv
design/radix_string_to_int_parser_core.sv
bench/tb_top.sv
